// File: design/cral_pkg.sv
// cral_pkg: shared types, command and status codes, saturation helpers
// for the complex register list alu; no dependencies
`timescale 1ns / 1ps

package cral_pkg;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_SUB    = 3'd2;
    localparam logic [2:0] CMD_MUL    = 3'd3;
    localparam logic [2:0] CMD_DIV    = 3'd4;
    localparam logic [2:0] CMD_DELETE = 3'd5;

    localparam logic [2:0] STAT_OK   = 3'd0;
    localparam logic [2:0] STAT_FULL = 3'd1;
    localparam logic [2:0] STAT_FEW  = 3'd2;
    localparam logic [2:0] STAT_POS  = 3'd3;
    localparam logic [2:0] STAT_DIV0 = 3'd4;

    // quotient bits produced by the long divider
    localparam int DIV_STEPS = 48;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] real_in;
        logic signed [31:0] imag_in;
        logic [4:0]         first_pos;
        logic [4:0]         second_pos;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result_real;
        logic signed [31:0] result_imag;
        logic [2:0]         status;
        logic [4:0]         entry_count;
    } out_t;

    // apply a sign to a magnitude and clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [64:0] mag);
        logic signed [31:0] r;
        if (neg) begin
            if (mag >= 65'h0_8000_0000) r = Q_MIN;
            else                        r = -$signed(mag[31:0]);
        end else begin
            if (mag > 65'h0_7FFF_FFFF) r = Q_MAX;
            else                       r = $signed(mag[31:0]);
        end
        return r;
    endfunction

    // clamp a signed 65-bit value to the signed 32-bit range
    function automatic logic signed [31:0] sat65(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sh0_7FFF_FFFF)       r = Q_MAX;
        else if (v < -65'sh0_8000_0000) r = Q_MIN;
        else                            r = v[31:0];
        return r;
    endfunction

endpackage

// File: design/complex_register_list_alu.sv
// complex_register_list_alu: top level, list of complex q16.16 entries with
// add, subtract, multiply, divide, append and delete; depends on cral_pkg,
// cral_ram and cral_div
//
// usage:
//  - input channel s_valid / s_ready / s_payload carries one command per transfer
//  - result channel m_valid / m_ready / m_payload returns exactly one result
//    per command: real and imaginary parts, status and the entry count after it
//  - one command is worked on at a time; s_ready is high only while idle
//  - delete moves every later entry down by one, reading and then writing
//    one entry at a time (the memory has one read and one write port)
//  - divide time is set by the 48-step restoring dividers (two, real and imag)
//  - the result waits in an output register; while the receiver stalls the
//    block keeps working and holds a finished result until the register frees
//  - synchronous active-low reset clears the count and handshakes; entry
//    storage is not cleared, only entries below the count are ever read
`timescale 1ns / 1ps

module complex_register_list_alu #(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cral_pkg::in_t    s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output cral_pkg::out_t   m_payload
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_OPA    = 4'd1;
    localparam logic [3:0] S_OPB    = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_NARROW = 4'd5;
    localparam logic [3:0] S_DIVS   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DEL_RD = 4'd8;
    localparam logic [3:0] S_DEL_WR = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [2:0]    cmd_reg;
    logic [XW-1:0] p2_reg;

    // operands and products
    logic signed [31:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [63:0] prod_reg [6];
    logic [2:0]         mcnt_reg;
    logic signed [64:0] sre_reg, sim_reg;
    logic [63:0]        den_reg;

    logic signed [31:0] res_real_reg, res_imag_reg;
    logic [2:0]         res_status_reg;

    cral_pkg::out_t     out_reg;
    logic               m_valid_reg;

    // memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [63:0]   mem_wdata, mem_rdata;

    logic          accept;
    logic [XW-1:0] p1_x, p2_x, count_x;
    logic          p1_bad, p2_bad;
    logic [2:0]    acc_status;

    logic signed [31:0] mul_x, mul_y;
    logic signed [63:0] mul_p;

    logic               div_start;
    logic               div_re_done, div_im_done;
    logic signed [31:0] div_re_q, div_im_q;
    logic [64:0]        sre_mag, sim_mag, sre_rnd, sim_rnd;

    logic signed [64:0] a_x, b_x, rd_re_x, rd_im_x;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    assign p1_x    = XW'(s_payload.first_pos);
    assign p2_x    = XW'(s_payload.second_pos);
    assign count_x = XW'(count_reg);
    assign p1_bad  = (p1_x == '0) || (p1_x > count_x);
    assign p2_bad  = (p2_x == '0) || (p2_x > count_x);

    // status known at the input transfer
    always_comb begin
        acc_status = cral_pkg::STAT_OK;
        unique case (s_payload.cmd) inside
            cral_pkg::CMD_APPEND: begin
                if (count_x >= XW'(CAPACITY)) acc_status = cral_pkg::STAT_FULL;
            end
            cral_pkg::CMD_DELETE: begin
                if (count_reg == '0) acc_status = cral_pkg::STAT_FEW;
                else if (p1_bad)     acc_status = cral_pkg::STAT_POS;
            end
            cral_pkg::CMD_ADD, cral_pkg::CMD_SUB,
            cral_pkg::CMD_MUL, cral_pkg::CMD_DIV: begin
                if (count_x < XW'(2))      acc_status = cral_pkg::STAT_FEW;
                else if (p1_bad || p2_bad) acc_status = cral_pkg::STAT_POS;
            end
            default: begin
            end
        endcase
    end

    cral_ram #(
        .WIDTH(64),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // single shared multiplier, one product per cycle
    always_comb begin
        case (mcnt_reg)
            3'd0:    begin mul_x = a_reg; mul_y = c_reg; end
            3'd1:    begin mul_x = b_reg; mul_y = d_reg; end
            3'd2:    begin mul_x = a_reg; mul_y = d_reg; end
            3'd3:    begin mul_x = b_reg; mul_y = c_reg; end
            3'd4:    begin mul_x = c_reg; mul_y = c_reg; end
            default: begin mul_x = d_reg; mul_y = d_reg; end
        endcase
    end
    assign mul_p = mul_x * mul_y;

    // q32.32 back to q16.16, round half away from zero
    assign sre_mag = sre_reg[64] ? 65'(-sre_reg) : 65'(sre_reg);
    assign sim_mag = sim_reg[64] ? 65'(-sim_reg) : 65'(sim_reg);
    assign sre_rnd = (sre_mag + 65'h8000) >> 16;
    assign sim_rnd = (sim_mag + 65'h8000) >> 16;

    assign div_start = (state_reg == S_DIVS) && (den_reg != '0);

    cral_div u_div_re (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_mag (sre_mag[63:0]),
        .num_neg (sre_reg[64]),
        .den     (den_reg),
        .done    (div_re_done),
        .quot    (div_re_q)
    );

    cral_div u_div_im (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_mag (sim_mag[63:0]),
        .num_neg (sim_reg[64]),
        .den     (den_reg),
        .done    (div_im_done),
        .quot    (div_im_q)
    );

    assign a_x     = 65'(a_reg);
    assign b_x     = 65'(b_reg);
    assign rd_re_x = 65'($signed(mem_rdata[63:32]));
    assign rd_im_x = 65'($signed(mem_rdata[31:0]));

    // control sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = '0;
        unique case (state_reg)
            S_IDLE: begin
                mem_raddr = AW'(p1_x - XW'(1));
                if (accept) begin
                    state_next = S_FIN;
                    unique case (s_payload.cmd) inside
                        cral_pkg::CMD_APPEND: begin
                            if (count_x < XW'(CAPACITY)) begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = {s_payload.real_in, s_payload.imag_in};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        cral_pkg::CMD_DELETE: begin
                            if (count_reg != '0 && !p1_bad) begin
                                idx_next = AW'(p1_x - XW'(1));
                                if (p1_x < count_x) state_next = S_DEL_RD;
                                else                count_next = count_reg - CW'(1);
                            end
                        end
                        cral_pkg::CMD_ADD, cral_pkg::CMD_SUB,
                        cral_pkg::CMD_MUL, cral_pkg::CMD_DIV: begin
                            if (count_x >= XW'(2) && !p1_bad && !p2_bad) begin
                                state_next = S_OPA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_OPA: begin
                mem_raddr  = AW'(p2_reg - XW'(1));
                state_next = S_OPB;
            end
            S_OPB: begin
                if (cmd_reg == cral_pkg::CMD_MUL || cmd_reg == cral_pkg::CMD_DIV) begin
                    state_next = S_MUL;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_MUL: begin
                if ((cmd_reg == cral_pkg::CMD_MUL && mcnt_reg == 3'd3) || mcnt_reg == 3'd5) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                state_next = (cmd_reg == cral_pkg::CMD_MUL) ? S_NARROW : S_DIVS;
            end
            S_NARROW: state_next = S_FIN;
            S_DIVS:   state_next = (den_reg != '0) ? S_DIV : S_FIN;
            S_DIV: begin
                if (div_re_done && div_im_done) state_next = S_FIN;
            end
            S_DEL_RD: begin
                mem_raddr  = AW'(XW'(idx_reg) + XW'(1));
                state_next = S_DEL_WR;
            end
            S_DEL_WR: begin
                // move the next entry down by one
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if (XW'(idx_reg) + XW'(2) < count_x) begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_DEL_RD;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_reg        <= s_payload.cmd;
                    p2_reg         <= p2_x;
                    res_real_reg   <= '0;
                    res_imag_reg   <= '0;
                    res_status_reg <= acc_status;
                    mcnt_reg       <= '0;
                end
            end
            S_OPA: begin
                a_reg <= $signed(mem_rdata[63:32]);
                b_reg <= $signed(mem_rdata[31:0]);
            end
            S_OPB: begin
                c_reg <= $signed(mem_rdata[63:32]);
                d_reg <= $signed(mem_rdata[31:0]);
                if (cmd_reg == cral_pkg::CMD_ADD) begin
                    res_real_reg <= cral_pkg::sat65(a_x + rd_re_x);
                    res_imag_reg <= cral_pkg::sat65(b_x + rd_im_x);
                end else if (cmd_reg == cral_pkg::CMD_SUB) begin
                    res_real_reg <= cral_pkg::sat65(a_x - rd_re_x);
                    res_imag_reg <= cral_pkg::sat65(b_x - rd_im_x);
                end
            end
            S_MUL: begin
                prod_reg[mcnt_reg] <= mul_p;
                mcnt_reg           <= mcnt_reg + 3'd1;
            end
            S_SUM: begin
                // products: ac, bd, ad, bc, cc, dd
                if (cmd_reg == cral_pkg::CMD_MUL) begin
                    sre_reg <= 65'(prod_reg[0]) - 65'(prod_reg[1]);
                    sim_reg <= 65'(prod_reg[2]) + 65'(prod_reg[3]);
                end else begin
                    sre_reg <= 65'(prod_reg[0]) + 65'(prod_reg[1]);
                    sim_reg <= 65'(prod_reg[3]) - 65'(prod_reg[2]);
                end
                den_reg <= $unsigned(prod_reg[4]) + $unsigned(prod_reg[5]);
            end
            S_NARROW: begin
                res_real_reg <= cral_pkg::sat_mag(sre_reg[64], sre_rnd);
                res_imag_reg <= cral_pkg::sat_mag(sim_reg[64], sim_rnd);
            end
            S_DIVS: begin
                if (den_reg == '0) res_status_reg <= cral_pkg::STAT_DIV0;
            end
            S_DIV: begin
                if (div_re_done && div_im_done) begin
                    res_real_reg <= div_re_q;
                    res_imag_reg <= div_im_q;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_reg.result_real <= res_real_reg;
                    out_reg.result_imag <= res_imag_reg;
                    out_reg.status      <= res_status_reg;
                    out_reg.entry_count <= count_x[4:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

// File: design/cral_ram.sv
// cral_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cral_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/cral_div.sv
// cral_div: restoring long divider, one quotient bit per cycle, gives
// round(num * 2^16 / den) with sign and saturation; depends on cral_pkg
`timescale 1ns / 1ps

module cral_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [63:0]        num_mag,
    input  logic               num_neg,
    input  logic [63:0]        den,
    output logic               done,
    output logic signed [31:0] quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [47:0] shf_reg;
    logic [47:0] quo_reg;
    logic [63:0] den_reg;
    logic        neg_reg;
    logic        sat_reg;

    logic        sat_now;
    logic [64:0] trial;
    logic        ge;
    logic [64:0] diff;
    logic [48:0] rounded;
    logic [64:0] q_mag;

    // integer quotient at or above 2^31 saturates
    assign sat_now = {31'd0, num_mag[63:31]} >= den;
    assign trial   = {rem_reg, shf_reg[47]};
    assign ge      = trial >= {1'b0, den_reg};
    assign diff    = trial - {1'b0, den_reg};
    assign rounded = ({1'b0, quo_reg} + 49'd1) >> 1;
    assign q_mag   = sat_reg ? 65'h0_8000_0000 : {16'd0, rounded};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= !sat_now;
            done_reg <= sat_now;
            cnt_reg  <= 6'(cral_pkg::DIV_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {31'd0, num_mag[63:31]};
            shf_reg <= {num_mag[30:0], 17'd0};
            quo_reg <= '0;
            den_reg <= den;
            neg_reg <= num_neg;
            sat_reg <= sat_now;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[63:0] : trial[63:0];
            quo_reg <= {quo_reg[46:0], ge};
            shf_reg <= {shf_reg[46:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign quot = cral_pkg::sat_mag(neg_reg, q_mag);

endmodule
